// ===== rtl/fssa_pkg.sv =====
// fssa_pkg: request and result types and status codes of the free slot allocator
`timescale 1ns / 1ps

package fssa_pkg;

    localparam int ACTION_W = 1;
    localparam int SLOT_IN_W = 9;
    localparam int SLOT_OUT_W = 8;
    localparam int STATUS_W = 3;

    localparam logic [ACTION_W-1:0] ACTION_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FREED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [SLOT_IN_W-1:0] slot_to_free;
    } request_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_given;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage

// ===== rtl/fssa_ram.sv =====
// fssa_ram: simple dual-port synchronous ram, one write and one registered read port
`timescale 1ns / 1ps

module fssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/free_slot_stack_allocator_core.sv =====
// free_slot_stack_allocator_core: stack based slot allocator with double-free check
//
//  channel  | handshake            | payload             | direction
//  ---------+----------------------+---------------------+----------
//  request  | start / busy         | request (request_t) | in
//  result   | done (1-cycle pulse) | result (result_t)   | out
//
// a request is accepted in IDLE, which reads the stack top and the slot's
// free bit from the two rams; EXEC checks, writes back and registers the
// result, which shows on done for one cycle while a new request may already
// be accepted. no clearing pass after reset: entries below the low-water mark
// of the free count are taken as initial values (a stack entry holds its own
// index, a slot is free), not read from the rams. the receiver cannot stall.
`timescale 1ns / 1ps

module free_slot_stack_allocator_core
    import fssa_pkg::*;
#(
    parameter int POOL_SLOTS = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(POOL_SLOTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic          state_reg, state_next;
    request_t      req_reg, req_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] low_reg, low_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic          accept;
    logic [CW-1:0] count_dec;
    logic [SW-1:0] top_idx;
    logic          fresh;
    logic [SW-1:0] pop_slot;
    logic [SW-1:0] slot_addr;
    logic          in_range;
    logic          slot_was_free;

    logic          stack_we;
    logic [SW-1:0] stack_waddr;
    logic [SW-1:0] stack_wdata;
    logic [SW-1:0] stack_rdata;
    logic          fbit_we;
    logic [SW-1:0] fbit_waddr;
    logic          fbit_wdata;
    logic          fbit_rdata;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;
    assign result = result_reg;

    assign count_dec = count_reg - CW'(1);
    assign top_idx = count_dec[SW-1:0];
    // at the low-water mark the top entry was never written since reset
    assign fresh = (count_reg == low_reg);
    assign pop_slot = fresh ? top_idx : stack_rdata;
    assign slot_addr = SW'(req_reg.slot_to_free);
    assign in_range = (int'(req_reg.slot_to_free) < POOL_SLOTS);
    // slots below the low-water mark were never handed out
    assign slot_was_free = (CW'(slot_addr) < low_reg) ? 1'b1 : fbit_rdata;

    fssa_ram #(
        .WIDTH (SW),
        .DEPTH (POOL_SLOTS),
        .AW    (SW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stack_we),
        .wr_addr (stack_waddr),
        .wr_data (stack_wdata),
        .rd_en   (accept),
        .rd_addr (top_idx),
        .rd_data (stack_rdata)
    );

    fssa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_SLOTS),
        .AW    (SW)
    ) u_free_bits (
        .clk     (clk),
        .wr_en   (fbit_we),
        .wr_addr (fbit_waddr),
        .wr_data (fbit_wdata),
        .rd_en   (accept),
        .rd_addr (SW'(request.slot_to_free)),
        .rd_data (fbit_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        count_next = count_reg;
        low_next = low_reg;
        done_next = 1'b0;
        result_next = result_reg;
        stack_we = 1'b0;
        stack_waddr = count_reg[SW-1:0];
        stack_wdata = slot_addr;
        fbit_we = 1'b0;
        fbit_waddr = slot_addr;
        fbit_wdata = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = request;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next = 1'b1;
                result_next.slot_given = '0;
                if (req_reg.action == ACTION_ALLOC)
                begin
                    if (count_reg == '0)
                    begin
                        result_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_dec;
                        if (fresh)
                        begin
                            low_next = count_dec;
                        end
                        fbit_we = 1'b1;
                        fbit_waddr = pop_slot;
                        fbit_wdata = 1'b0;
                        result_next.slot_given = SLOT_OUT_W'(pop_slot);
                        result_next.status = STATUS_ALLOCATED;
                    end
                end
                else
                begin
                    priority if (!in_range)
                    begin
                        result_next.status = STATUS_RANGE;
                    end
                    else if (slot_was_free || (count_reg >= COUNT_FULL))
                    begin
                        result_next.status = STATUS_ALREADY;
                    end
                    else
                    begin
                        stack_we = 1'b1;
                        fbit_we = 1'b1;
                        count_next = count_reg + CW'(1);
                        result_next.status = STATUS_FREED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_FULL;
            low_reg <= COUNT_FULL;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            low_reg <= low_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/fssa_checker.sv =====
// fssa_checker: port-level assertions for the allocator core, bound to the top level
`timescale 1ns / 1ps

module fssa_checker
    import fssa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // an accepted request is worked on while busy is high, and done follows in the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 done)
        else $error("request not answered two cycles after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("result reported while a request is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !$past(busy, 2)))
        else $error("result without a matching request");

    // only an allocation hands out a slot number
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STATUS_ALLOCATED)) |-> (result.slot_given == '0))
        else $error("slot number given on a result that is not an allocation");

endmodule

bind free_slot_stack_allocator_core fssa_checker u_fssa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
